### hw/rtl/kmcd_pkg.sv
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types and constants for the key matrix column debouncer.
// ----------------------------------------------------------------------------
package kmcd_pkg;

    localparam int ROW_COUNT    = 8;
    localparam int COLUMN_COUNT = 16;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 4;
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 8;
    localparam int COL_AW  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ROW_W-1:0] ROW_MASK       = ROW_W'((64'd1 << ROW_COUNT) - 64'd1);
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(5);

    typedef struct packed {
        logic [ROW_W-1:0]  cand;
        logic [ROW_W-1:0]  stable;
        logic [TIME_W-1:0] change_time;
        logic              waiting;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [COL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [COL_AW-1:0] wr_addr;
    } store_req_t;

endpackage

### hw/rtl/key_matrix_column_debouncer.sv
// ----------------------------------------------------------------------------
// key_matrix_column_debouncer
// Per-column debouncer for a scanned key matrix.
// ----------------------------------------------------------------------------
// Takes one column beat per clock while the output is not stalled and returns
// one result beat per input beat via the stage 1 and output registers. The
// rate is set by the per-column state memory: one read at acceptance, one
// write-back as the beat leaves stage 1, forwarded to a same-column read in
// that cycle. State starts cleared out of reset (per-entry valid bits), so
// no clearing pass. debounce_ms must be written only while idle (unenforced).
// ----------------------------------------------------------------------------
module key_matrix_column_debouncer
    import kmcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   debounce_ms_wr_en,
    input  logic [DEB_W-1:0]       debounce_ms_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] column_index, [11:4] row_levels, [43:12] now_ms, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] column_out, [11:4] stable_rows, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] accepted
    output logic [0:0]             m_axis_tuser
);

    logic [DEB_W-1:0]  debounce_ms_reg;

    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_pressed;
    logic [TIME_W-1:0] in_now;
    logic              in_range;
    logic              s_accept;

    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_pressed_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_in_range_reg;
    logic              s1_adv;

    store_req_t        req;
    entry_t            old_entry;
    entry_t            entry_next;
    logic              s1_changed;
    logic              s1_acc;
    logic [TIME_W-1:0] elapsed;

    logic              o_valid_reg;
    logic [COL_W-1:0]  o_col_reg;
    logic [ROW_W-1:0]  o_stable_reg;
    logic              o_acc_reg;

    assign in_col     = s_axis_tdata[3:0];
    assign in_pressed = ~s_axis_tdata[11:4] & ROW_MASK;
    assign in_now     = s_axis_tdata[43:12];
    assign in_range   = int'(in_col) < COLUMN_COUNT;

    assign s1_adv        = s1_valid_reg && (!o_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= DEBOUNCE_RESET;
        end
        else if (debounce_ms_wr_en)
        begin
            debounce_ms_reg <= debounce_ms_wdata;
        end
    end

    // state read at acceptance, write-back when the beat leaves stage 1
    assign req.rd_en   = s_accept && in_range;
    assign req.rd_addr = COL_AW'(in_col);
    assign req.wr_en   = s1_adv && s1_in_range_reg;
    assign req.wr_addr = COL_AW'(s1_col_reg);

    kmcd_column_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .wr_data (entry_next),
        .rd_data (old_entry)
    );

    assign elapsed    = s1_now_reg - old_entry.change_time;
    assign s1_changed = old_entry.cand != s1_pressed_reg;
    assign s1_acc     = s1_in_range_reg && !s1_changed && old_entry.waiting &&
                        (elapsed >= TIME_W'(debounce_ms_reg));

    always_comb
    begin
        entry_next = old_entry;
        if (s1_changed)
        begin
            entry_next.cand        = s1_pressed_reg;
            entry_next.change_time = s1_now_reg;
            entry_next.waiting     = 1'b1;
        end
        else if (s1_acc)
        begin
            entry_next.stable  = old_entry.cand;
            entry_next.waiting = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_col_reg      <= in_col;
            s1_pressed_reg  <= in_pressed;
            s1_now_reg      <= in_now;
            s1_in_range_reg <= in_range;
        end
        if (s1_adv)
        begin
            o_col_reg    <= s1_col_reg;
            o_stable_reg <= s1_in_range_reg ? entry_next.stable : '0;
            o_acc_reg    <= s1_acc;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - COL_W - ROW_W)'(0), o_stable_reg, o_col_reg};
    assign m_axis_tuser  = o_acc_reg;

    // stalled beat in stage 1 keeps its column
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stage 1 beat lost while stalled");

    // a changed pattern never accepts and always leaves the entry waiting
    a_change_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && s1_changed) |-> (entry_next.waiting && !s1_acc))
        else $error("changed pattern accepted or not pending");

    // an acceptance reaches the output register as a flagged beat
    a_acc_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_acc) |=> (m_axis_tvalid && m_axis_tuser[0]))
        else $error("acceptance not flagged on output");

    // memory writes only when a beat leaves stage 1
    a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> s1_valid_reg)
        else $error("state write without a beat");

endmodule

### hw/rtl/kmcd_column_store.sv
// ----------------------------------------------------------------------------
// kmcd_column_store
// Per-column state memory, one read and one write port, read data registered.
// Valid bits give cleared entries after reset; a write that lands on the
// address being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module kmcd_column_store
    import kmcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    input  entry_t     wr_data,
    output entry_t     rd_data
);

    entry_t                  mem [COLUMN_COUNT];
    entry_t                  mem_q_reg;
    entry_t                  hit_data_reg;
    logic [COLUMN_COUNT-1:0] valid_reg;
    logic                    rd_valid_reg;
    logic                    hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg    <= mem[req.rd_addr];
            hit_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
                hit_reg      <= req.wr_en && (req.wr_addr == req.rd_addr);
            end
        end
    end

    assign rd_data = hit_reg      ? hit_data_reg :
                     rd_valid_reg ? mem_q_reg    : '0;

endmodule
